// ===== sv/lrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrs_pkg: shared types and constants of the link reconnect supervisor
// Operation codes, LED and peer-link codes, register indexes and reset
// values, and the structs passed between the supervisor's modules.
// ----------------------------------------------------------------------------
package lrs_pkg;

	// Item operation codes
	localparam logic [1:0] OP_POLL         = 2'd0;
	localparam logic [1:0] OP_CONNECTED    = 2'd1;
	localparam logic [1:0] OP_DISCONNECTED = 2'd2;
	localparam logic [1:0] OP_STA_START    = 2'd3;

	// LED styles
	localparam logic [1:0] LED_UNSET = 2'd0;
	localparam logic [1:0] LED_BLINK = 2'd1;
	localparam logic [1:0] LED_ON    = 2'd2;
	localparam logic [1:0] LED_SLOW  = 2'd3;

	// Peer-link states
	localparam logic [1:0] PEER_IDLE    = 2'd0;
	localparam logic [1:0] PEER_ONLINE  = 2'd1;
	localparam logic [1:0] PEER_OFFLINE = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTVL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFLINE_TMO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS  = 3'd4;

	localparam int unsigned CFG_DATA_W = 32;

	// Register reset values
	localparam logic [15:0] DEBOUNCE_RST     = 16'd250;
	localparam logic [15:0] LONG_PRESS_RST   = 16'd3000;
	localparam logic [31:0] RETRY_INTVL_RST  = 32'd10000;
	localparam logic [31:0] OFFLINE_TMO_RST  = 32'd300000;
	localparam logic [5:0]  MAX_ATTEMPTS_RST = 6'd30;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] long_press_ms;
		logic [31:0] retry_interval_ms;
		logic [31:0] offline_timeout_ms;
		logic [5:0]  max_attempts;
	} cfg_t;

	// Link-side status after an item has been applied
	typedef struct packed {
		logic [1:0] led_style;
		logic [1:0] peer_link_state;
		logic       offline_active;
		logic [5:0] attempt_count;
	} link_stat_t;

	// Link-side pulses of one poll
	typedef struct packed {
		logic begin_connect;
		logic reconnect_request;
		logic update_check_due;
	} link_pulse_t;

endpackage

// ===== sv/link_reconnect_supervisor.sv =====
// ----------------------------------------------------------------------------
// link_reconnect_supervisor: button and link reconnect supervisor
// Debounces the provisioning button and supervises link loss, reconnect
// pacing and offline mode; one result item for each input item.
// ----------------------------------------------------------------------------
//  Channel  Handshake               Payload
//  in       in_valid / in_stall     operation, time_ms, button_level, link_up
//  out      out_valid / out_stall   start_provisioning .. button_pressed
//  cfg      cfg_write               cfg_index, cfg_data
//
// An item is taken into the input register, processed combinationally and its
// result is written to the output register; one item is accepted every cycle
// while the output is not stalled.
// The input register keeps taking an item while a result waits in the
// output register; in_stall rises only when both are full and out is stalled.
// Reset restores the register defaults and clears all supervisor state.
// ----------------------------------------------------------------------------
module link_reconnect_supervisor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          operation,
	input  logic [31:0]                         time_ms,
	input  logic                                button_level,
	input  logic                                link_up,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                start_provisioning,
	output logic                                begin_connect,
	output logic                                reconnect_request,
	output logic                                update_check_due,
	output logic [1:0]                          led_style,
	output logic [1:0]                          peer_link_state,
	output logic                                offline_active,
	output logic [5:0]                          attempt_count,
	output logic                                button_pressed,
	input  logic                                cfg_write,
	input  logic [lrs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lrs_pkg::CFG_DATA_W-1:0]      cfg_data
);

	lrs_pkg::cfg_t        cfg_q;

	logic                 valid_s1;
	logic [1:0]           op_s1;
	logic [31:0]          time_s1;
	logic                 button_s1;
	logic                 link_s1;

	logic                 adv;
	logic                 take;
	logic                 is_poll;
	logic                 prov;
	logic                 debounced_nxt;
	logic                 debounced_cur;
	lrs_pkg::link_pulse_t pulse;
	lrs_pkg::link_stat_t  stat_nxt;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms        <= lrs_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ms      <= lrs_pkg::LONG_PRESS_RST;
			cfg_q.retry_interval_ms  <= lrs_pkg::RETRY_INTVL_RST;
			cfg_q.offline_timeout_ms <= lrs_pkg::OFFLINE_TMO_RST;
			cfg_q.max_attempts       <= lrs_pkg::MAX_ATTEMPTS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				lrs_pkg::REG_DEBOUNCE:     cfg_q.debounce_ms        <= cfg_data[15:0];
				lrs_pkg::REG_LONG_PRESS:   cfg_q.long_press_ms      <= cfg_data[15:0];
				lrs_pkg::REG_RETRY_INTVL:  cfg_q.retry_interval_ms  <= cfg_data[31:0];
				lrs_pkg::REG_OFFLINE_TMO:  cfg_q.offline_timeout_ms <= cfg_data[31:0];
				lrs_pkg::REG_MAX_ATTEMPTS: cfg_q.max_attempts       <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// The held item moves on when the output register is empty or drains.
	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;
	assign is_poll  = (op_s1 == lrs_pkg::OP_POLL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1     <= operation;
			time_s1   <= time_ms;
			button_s1 <= button_level;
			link_s1   <= link_up;
		end
	end

	lrs_button u_button (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv && is_poll),
		.now           (time_s1),
		.pressed       (~button_s1),
		.cfg           (cfg_q),
		.prov          (prov),
		.debounced_nxt (debounced_nxt),
		.debounced     (debounced_cur)
	);

	lrs_link u_link (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.op       (op_s1),
		.now      (time_s1),
		.up       (link_s1),
		.cfg      (cfg_q),
		.pulse    (pulse),
		.stat_nxt (stat_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Event items carry no pulses and leave the button state alone.
			start_provisioning <= is_poll && prov;
			begin_connect      <= pulse.begin_connect;
			reconnect_request  <= pulse.reconnect_request;
			update_check_due   <= pulse.update_check_due;
			led_style          <= stat_nxt.led_style;
			peer_link_state    <= stat_nxt.peer_link_state;
			offline_active     <= stat_nxt.offline_active;
			attempt_count      <= stat_nxt.attempt_count;
			button_pressed     <= is_poll ? debounced_nxt : debounced_cur;
		end
	end

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with no item held");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("processed item produced no result");

	a_one_link_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(begin_connect && reconnect_request))
		else $error("fresh connect and reconnect in one result");

	a_begin_leaves_offline: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && begin_connect) |-> (!offline_active && attempt_count == 6'd1))
		else $error("fresh connect without leaving offline mode");

	a_retry_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reconnect_request) |-> (attempt_count != 6'd0))
		else $error("reconnect issued without counting the attempt");

endmodule

// ===== sv/lrs_button.sv =====
// ----------------------------------------------------------------------------
// lrs_button: button debounce and long-press detection
// Tracks the raw level, debounces it and flags a long press once per hold.
// The next state is worked out combinationally and taken on en.
// ----------------------------------------------------------------------------
module lrs_button (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [31:0]        now,
	input  logic               pressed,
	input  lrs_pkg::cfg_t      cfg,
	output logic               prov,
	output logic               debounced_nxt,
	output logic               debounced
);

	logic        last_raw_q;
	logic [31:0] change_time_q;
	logic        debounced_q;
	logic        handled_q;

	logic        changed;
	logic [31:0] ct1;
	logic        ph1;
	logic [31:0] held;
	logic        ph_nxt;
	logic [31:0] ct_nxt;

	always_comb begin
		changed = (pressed != last_raw_q);
		ct1     = changed ? now : change_time_q;
		ph1     = (changed && !pressed) ? 1'b0 : handled_q;
		held    = now - ct1;
		debounced_nxt = (held >= {16'd0, cfg.debounce_ms}) ? pressed : debounced_q;
		prov    = debounced_nxt && !ph1 && (held >= {16'd0, cfg.long_press_ms});
		ph_nxt  = prov ? 1'b1 : ph1;
		ct_nxt  = prov ? now : ct1;
	end

	assign debounced = debounced_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b0;
			change_time_q <= '0;
			debounced_q   <= 1'b0;
			handled_q     <= 1'b0;
		end else if (en) begin
			last_raw_q    <= pressed;
			change_time_q <= ct_nxt;
			debounced_q   <= debounced_nxt;
			handled_q     <= ph_nxt;
		end
	end

endmodule

// ===== sv/lrs_link.sv =====
// ----------------------------------------------------------------------------
// lrs_link: link supervision
// Paces reconnect requests, enters and leaves offline mode, and keeps the
// LED style and peer-link state from polls and link events.
// ----------------------------------------------------------------------------
module lrs_link (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [1:0]           op,
	input  logic [31:0]          now,
	input  logic                 up,
	input  lrs_pkg::cfg_t        cfg,
	output lrs_pkg::link_pulse_t pulse,
	output lrs_pkg::link_stat_t  stat_nxt
);

	logic        offline_q;
	logic [31:0] offline_start_q;
	logic [31:0] last_retry_q;
	logic [5:0]  attempts_q;
	logic        pending_q;
	logic [1:0]  led_q;
	logic [1:0]  peer_q;

	logic        offline_n;
	logic [31:0] offline_start_n;
	logic [31:0] last_retry_n;
	logic [5:0]  attempts_n;
	logic        pending_n;
	logic [1:0]  led_n;
	logic [1:0]  peer_n;

	logic [31:0] off_elapsed;
	logic [31:0] retry_elapsed;

	always_comb begin
		offline_n       = offline_q;
		offline_start_n = offline_start_q;
		last_retry_n    = last_retry_q;
		attempts_n      = attempts_q;
		pending_n       = pending_q;
		led_n           = led_q;
		peer_n          = peer_q;
		pulse           = '0;
		off_elapsed     = now - offline_start_q;
		retry_elapsed   = now - last_retry_q;

		unique case (op)
			lrs_pkg::OP_POLL: begin
				if (up) begin
					attempts_n = '0;
					pulse.update_check_due = 1'b1;
				end else if (offline_q) begin
					if (off_elapsed >= cfg.offline_timeout_ms) begin
						offline_n    = 1'b0;
						attempts_n   = 6'd1;
						last_retry_n = now;
						pulse.begin_connect = 1'b1;
					end
				end else if (attempts_q >= cfg.max_attempts) begin
					peer_n          = lrs_pkg::PEER_OFFLINE;
					offline_start_n = now;
					offline_n       = 1'b1;
					led_n           = lrs_pkg::LED_SLOW;
				end else if (pending_q && (retry_elapsed >= cfg.retry_interval_ms)) begin
					// Below max_attempts here, so the count cannot wrap.
					attempts_n   = attempts_q + 6'd1;
					last_retry_n = now;
					pending_n    = 1'b0;
					pulse.reconnect_request = 1'b1;
				end
			end
			lrs_pkg::OP_CONNECTED: begin
				peer_n     = lrs_pkg::PEER_ONLINE;
				led_n      = lrs_pkg::LED_ON;
				attempts_n = '0;
			end
			lrs_pkg::OP_DISCONNECTED: begin
				led_n     = lrs_pkg::LED_BLINK;
				peer_n    = lrs_pkg::PEER_IDLE;
				pending_n = 1'b1;
			end
			default: begin
				led_n = lrs_pkg::LED_BLINK;
			end
		endcase

		stat_nxt.led_style       = led_n;
		stat_nxt.peer_link_state = peer_n;
		stat_nxt.offline_active  = offline_n;
		stat_nxt.attempt_count   = attempts_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offline_q       <= 1'b0;
			offline_start_q <= '0;
			last_retry_q    <= '0;
			attempts_q      <= '0;
			pending_q       <= 1'b0;
			led_q           <= lrs_pkg::LED_UNSET;
			peer_q          <= lrs_pkg::PEER_IDLE;
		end else if (en) begin
			offline_q       <= offline_n;
			offline_start_q <= offline_start_n;
			last_retry_q    <= last_retry_n;
			attempts_q      <= attempts_n;
			pending_q       <= pending_n;
			led_q           <= led_n;
			peer_q          <= peer_n;
		end
	end

endmodule

// ===== tb/link_reconnect_supervisor_tb.sv =====
// ----------------------------------------------------------------------------
// link_reconnect_supervisor_tb: self-checking bench for the reconnect supervisor
// Drives polls and link events through the valid/stall input channel, rebuilds
// the expected status of every item with a cycle-free model of the button
// debouncer and reconnect logic, and compares each result field by field.
// The run covers directed corner cases, then random link and
// button histories under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module link_reconnect_supervisor_tb;

	localparam int unsigned PERIOD    = 4;
	// Time limit of the watchdog that ends a hung run.
	localparam int unsigned RUN_LIMIT = 800000;
	localparam int unsigned PER_SETTING = 150;

	typedef struct packed {
		logic       provisioning;
		logic       fresh_connect;
		logic       reconnect;
		logic       update_due;
		logic [1:0] led;
		logic [1:0] peer;
		logic       offline;
		logic [5:0] attempts;
		logic       pressed;
	} status_t;

	class supervisor_checker;
		logic [15:0] debounce_ms, long_press_ms;
		logic [31:0] retry_ms, offline_ms;
		logic [5:0]  attempt_limit;
		logic        raw_pressed, deb_pressed, press_done, offline, reconnect_armed;
		logic [31:0] change_t, offline_t, retry_t;
		logic [5:0]  attempts;
		logic [1:0]  led, peer;
		status_t     expected_status_q[$];
		int unsigned errors, checked;
		int unsigned n_prov, n_fresh, n_retry, n_update, n_offline;

		function void clear();
			debounce_ms   = lrs_pkg::DEBOUNCE_RST;
			long_press_ms = lrs_pkg::LONG_PRESS_RST;
			retry_ms      = lrs_pkg::RETRY_INTVL_RST;
			offline_ms    = lrs_pkg::OFFLINE_TMO_RST;
			attempt_limit = lrs_pkg::MAX_ATTEMPTS_RST;
			raw_pressed = 1'b0; deb_pressed = 1'b0; press_done = 1'b0;
			offline = 1'b0; reconnect_armed = 1'b0;
			change_t = '0; offline_t = '0; retry_t = '0;
			attempts = '0; led = lrs_pkg::LED_UNSET; peer = lrs_pkg::PEER_IDLE;
			expected_status_q.delete();
			errors = 0; checked = 0;
			n_prov = 0; n_fresh = 0; n_retry = 0; n_update = 0; n_offline = 0;
		endfunction

		// Registers narrower than the data bus keep only their low bits.
		function void set_reg(logic [lrs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
			lrs_pkg::REG_DEBOUNCE:     debounce_ms   = data[15:0];
			lrs_pkg::REG_LONG_PRESS:   long_press_ms = data[15:0];
			lrs_pkg::REG_RETRY_INTVL:  retry_ms      = data;
			lrs_pkg::REG_OFFLINE_TMO:  offline_ms    = data;
			lrs_pkg::REG_MAX_ATTEMPTS: attempt_limit = data[5:0];
			default: ;
			endcase
		endfunction

		function status_t predict_status(logic [1:0] op, logic [31:0] now, logic lvl,
				logic up);
			status_t     s;
			logic        pressed;
			logic [31:0] held;
			s = '0;
			pressed = ~lvl;
			case (op)
			lrs_pkg::OP_POLL: begin
				if (pressed != raw_pressed) begin
					raw_pressed = pressed;
					change_t = now;
					if (!pressed)
						press_done = 1'b0;
				end
				held = now - change_t;
				if (held >= {16'd0, debounce_ms})
					deb_pressed = pressed;
				if (deb_pressed && !press_done && held >= {16'd0, long_press_ms}) begin
					press_done = 1'b1;
					change_t = now;
					s.provisioning = 1'b1;
				end
				if (up) begin
					attempts = '0;
					s.update_due = 1'b1;
				end else if (offline) begin
					if (now - offline_t >= offline_ms) begin
						offline = 1'b0;
						attempts = 6'd1;
						retry_t = now;
						s.fresh_connect = 1'b1;
					end
				end else if (attempts >= attempt_limit) begin
					peer = lrs_pkg::PEER_OFFLINE;
					offline_t = now;
					offline = 1'b1;
					led = lrs_pkg::LED_SLOW;
					n_offline++;
				end else if (reconnect_armed && now - retry_t >= retry_ms) begin
					attempts = attempts + 6'd1;
					retry_t = now;
					reconnect_armed = 1'b0;
					s.reconnect = 1'b1;
				end
			end
			lrs_pkg::OP_CONNECTED: begin
				peer = lrs_pkg::PEER_ONLINE;
				led = lrs_pkg::LED_ON;
				attempts = '0;
			end
			lrs_pkg::OP_DISCONNECTED: begin
				led = lrs_pkg::LED_BLINK;
				peer = lrs_pkg::PEER_IDLE;
				reconnect_armed = 1'b1;
			end
			default: led = lrs_pkg::LED_BLINK;
			endcase
			s.led = led;
			s.peer = peer;
			s.offline = offline;
			s.attempts = attempts;
			s.pressed = deb_pressed;
			n_prov += s.provisioning;
			n_fresh += s.fresh_connect;
			n_retry += s.reconnect;
			n_update += s.update_due;
			return s;
		endfunction

		function void note_item(logic [1:0] op, logic [31:0] now, logic lvl, logic up);
			expected_status_q.push_back(predict_status(op, now, lvl, up));
		endfunction

		function string show(status_t s);
			return $sformatf(
				"prov=%0b conn=%0b retry=%0b upd=%0b led=%0d peer=%0d off=%0b att=%0d btn=%0b",
				s.provisioning, s.fresh_connect, s.reconnect, s.update_due, s.led, s.peer,
				s.offline, s.attempts, s.pressed);
		endfunction

		function void check_status(status_t got);
			status_t want;
			checked++;
			if (expected_status_q.size() == 0) begin
				errors++;
				if (errors <= 200)
					$display("%0t: result with nothing expected: %s", $time, show(got));
				return;
			end
			want = expected_status_q.pop_front();
			if (got.provisioning !== want.provisioning
					|| got.fresh_connect !== want.fresh_connect
					|| got.reconnect !== want.reconnect || got.update_due !== want.update_due
					|| got.led !== want.led || got.peer !== want.peer
					|| got.offline !== want.offline || got.attempts !== want.attempts
					|| got.pressed !== want.pressed) begin
				errors++;
				if (errors <= 200)
					$display("%0t: mismatch: expected %s, got %s", $time, show(want),
						show(got));
			end
		endfunction

		function int pending();
			return expected_status_q.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [1:0]                     operation = lrs_pkg::OP_POLL;
	logic [31:0]                    time_ms = '0;
	logic                           button_level = 1'b1;
	logic                           link_up = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic                           start_provisioning, begin_connect, reconnect_request;
	logic                           update_check_due;
	logic [1:0]                     led_style, peer_link_state;
	logic                           offline_active;
	logic [5:0]                     attempt_count;
	logic                           button_pressed;
	logic                           cfg_write = 1'b0;
	logic [lrs_pkg::CFG_IDX_W-1:0]  cfg_index = lrs_pkg::REG_DEBOUNCE;
	logic [lrs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	supervisor_checker sb;
	int unsigned       send_gap_pct = 0;
	int unsigned       recv_stall_pct = 0;
	int unsigned       step_max = 100;
	int unsigned       sent = 0;
	logic [31:0]       clock_ms = '0;
	logic              btn_lvl = 1'b1;
	logic              link_ok = 1'b0;

	link_reconnect_supervisor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .time_ms(time_ms),
		.button_level(button_level), .link_up(link_up),
		.out_valid(out_valid), .out_stall(out_stall),
		.start_provisioning(start_provisioning), .begin_connect(begin_connect),
		.reconnect_request(reconnect_request), .update_check_due(update_check_due),
		.led_style(led_style), .peer_link_state(peer_link_state),
		.offline_active(offline_active), .attempt_count(attempt_count),
		.button_pressed(button_pressed),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_item(operation, time_ms, button_level, link_up);
			if (out_valid && !out_stall)
				sb.check_status({start_provisioning, begin_connect, reconnect_request,
					update_check_due, led_style, peer_link_state, offline_active,
					attempt_count, button_pressed});
		end
	end

	// Entered and left at a falling edge; the item is held until it is taken.
	task automatic send_item(input logic [1:0] op, input logic [31:0] t, input logic lvl,
			input logic up);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		time_ms <= t;
		button_level <= lvl;
		link_up <= up;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [lrs_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic apply_setting(input int unsigned which);
		logic [31:0] dbn, lng, rty, otm, mxa;
		case (which)
		0: begin
			dbn = 0; lng = 0; rty = 0; otm = 0; mxa = 0;
			step_max = 20;
		end
		1: begin
			dbn = 5; lng = 40; rty = 30; otm = 200; mxa = 3;
			step_max = 25;
		end
		2: begin
			dbn = 16'hFFFF; lng = 16'hFFFF; rty = '1; otm = '1; mxa = 63;
			step_max = 40000;
		end
		default: begin
			// Upper bits above each register's width are junk and must be dropped.
			dbn = ($urandom() & 32'hFFFF_0000) | $urandom_range(0, 100);
			lng = ($urandom() & 32'hFFFF_0000) | $urandom_range(0, 600);
			rty = $urandom_range(0, 400);
			otm = $urandom_range(0, 3000);
			mxa = ($urandom() & 32'hFFFF_FFC0) | $urandom_range(1, 8);
			step_max = 120;
		end
		endcase
		write_reg(lrs_pkg::REG_DEBOUNCE, dbn);
		write_reg(lrs_pkg::REG_LONG_PRESS, lng);
		write_reg(lrs_pkg::REG_RETRY_INTVL, rty);
		write_reg(lrs_pkg::REG_OFFLINE_TMO, otm);
		write_reg(lrs_pkg::REG_MAX_ATTEMPTS, mxa);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly polls on a running clock with a link that drops and returns, with
	// repeated disconnect events while down so that attempts climb to the limit.
	task automatic random_item();
		int unsigned r;
		logic [31:0] d;
		logic [1:0]  op;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			link_ok = ~link_ok;
			send_item(link_ok ? lrs_pkg::OP_CONNECTED : lrs_pkg::OP_DISCONNECTED, $urandom(),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else if (!link_ok && r < 15) begin
			send_item(lrs_pkg::OP_DISCONNECTED, $urandom(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else if (r < 17) begin
			send_item(lrs_pkg::OP_STA_START, $urandom(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else if (r < 20) begin
			op = 2'($urandom_range(0, 3));
			send_item(op, $urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else begin
			case ($urandom_range(0, 19))
			0: d = 0;
			1: d = $urandom();
			2: d = $urandom_range(step_max * 8, step_max);
			default: d = $urandom_range(step_max, 1);
			endcase
			clock_ms += d;
			if ($urandom_range(0, 99) < 8)
				btn_lvl = ~btn_lvl;
			send_item(lrs_pkg::OP_POLL, clock_ms, btn_lvl,
				($urandom_range(0, 99) < 4) ? ~link_ok : link_ok);
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset register values.
		send_gap_pct = 13;
		recv_stall_pct = 59;
		send_item(lrs_pkg::OP_POLL, 32'd0, 1'b1, 1'b1);
		send_item(lrs_pkg::OP_STA_START, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_item(lrs_pkg::OP_CONNECTED, 32'h1234_5678, 1'b0, 1'b1);
		send_item(lrs_pkg::OP_DISCONNECTED, 32'd0, 1'b1, 1'b0);
		send_item(lrs_pkg::OP_POLL, 32'd100, 1'b1, 1'b0);
		send_item(lrs_pkg::OP_POLL, 32'd10000, 1'b1, 1'b0);
		send_item(lrs_pkg::OP_POLL, 32'd10010, 1'b0, 1'b0);
		send_item(lrs_pkg::OP_POLL, 32'd10260, 1'b0, 1'b0);
		send_item(lrs_pkg::OP_POLL, 32'd13010, 1'b0, 1'b0);
		// Still held after provisioning: no second pulse until released.
		send_item(lrs_pkg::OP_POLL, 32'd16020, 1'b0, 1'b0);
		send_item(lrs_pkg::OP_POLL, 32'd16030, 1'b1, 1'b1);
		send_item(lrs_pkg::OP_POLL, 32'd16280, 1'b1, 1'b1);
		send_item(lrs_pkg::OP_POLL, 32'd16281, 1'b0, 1'b1);
		send_item(lrs_pkg::OP_POLL, 32'd16300, 1'b1, 1'b1);
		// Press and retry timing across the wrap of the millisecond counter.
		send_item(lrs_pkg::OP_POLL, 32'hFFFF_FF00, 1'b0, 1'b0);
		send_item(lrs_pkg::OP_POLL, 32'h0000_0010, 1'b0, 1'b0);
		send_item(lrs_pkg::OP_DISCONNECTED, 32'hA5A5_A5A5, 1'b0, 1'b1);
		send_item(lrs_pkg::OP_POLL, 32'h0000_2000, 1'b0, 1'b0);
		send_item(lrs_pkg::OP_POLL, 32'h0000_2001, 1'b0, 1'b0);
		send_item(lrs_pkg::OP_CONNECTED, 32'h5A5A_5A5A, 1'b1, 1'b0);
		send_item(lrs_pkg::OP_POLL, 32'h0000_3000, 1'b1, 1'b1);
		send_item(lrs_pkg::OP_POLL, 32'hFFFF_FFFF, 1'b1, 1'b0);
		wait_quiet();

		for (int mode = 0; mode < 3; mode++) begin
			send_gap_pct = (mode == 0) ? 13 : (mode == 1) ? 59 : 0;
			recv_stall_pct = (mode == 0) ? 59 : (mode == 1) ? 13 : 0;
			for (int s = 0; s < 4; s++) begin
				apply_setting(s);
				for (int i = 0; i < PER_SETTING; i++)
					random_item();
				wait_quiet();
			end
		end

		$display("Sent %0d items and checked %0d results over the reset values and %s",
			sent, sb.checked, "four register settings.");
		$display("Seen: %0d provisioning, %0d fresh connects, %0d reconnects, %s",
			sb.n_prov, sb.n_fresh, sb.n_retry,
			$sformatf("%0d update checks, %0d offline entries.", sb.n_update, sb.n_offline));
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Timed out with %0d results still outstanding.", sb.pending());
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/lrs_pkg.sv
sv/lrs_button.sv
sv/lrs_link.sv
sv/link_reconnect_supervisor.sv
tb/link_reconnect_supervisor_tb.sv
